[design/rrts_pkg.sv]
// Package with shared types and constants for the round-robin tick scheduler.
`timescale 1ns / 1ps
package rrts_pkg;

  localparam int MaxProcs = 16;
  localparam int IdxW = $clog2(MaxProcs);
  localparam int CntW = $clog2(MaxProcs + 1);
  localparam int QDepth = 2;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_QUANTUM = 1'b0,
    REG_PCOUNT  = 1'b1
  } reg_e;

  typedef struct packed {
    logic        command;
    logic [3:0]  proc_index;
    logic [15:0] arrival_tick;
    logic [15:0] burst_length;
  } in_item_t;

  typedef struct packed {
    logic        running_valid;
    logic [3:0]  running_index;
    logic        finished;
    logic [15:0] finished_wait;
    logic [15:0] finished_turnaround;
    logic        all_done;
    logic [15:0] tick_now;
  } out_item_t;

  typedef struct packed {
    logic            is_tick;
    logic [IdxW-1:0] idx;
    logic            idx_ok;
    logic [15:0]     arrival;
    logic [15:0]     burst;
  } op_t;

  typedef struct packed {
    logic [15:0] quantum;
    logic [CntW-1:0] count;
  } cfg_t;

endpackage

[design/rrts_if.sv]
// Valid/ready stream interfaces for the scheduler.
`timescale 1ns / 1ps
interface rrts_in_if import rrts_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrts_out_if import rrts_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rrts_cfg_if ();
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [15:0] wdata;
  modport source (output valid, output index, output wdata, input ready);
  modport sink (input valid, input index, input wdata, output ready);
endinterface

[design/round_robin_tick_scheduler_unit.sv]
// Top level of the round-robin tick scheduler.
`timescale 1ns / 1ps
// The back end walks the process table one entry per cycle, over process_count
// entries (capped at sixteen): a load beat for the all-done check, a tick beat for
// arrivals, the pick and aging. A two-entry queue decouples input acceptance from
// that sequencer; the result register lets the sequencer start the next item while
// a result beat waits, and it stalls only when a second result is ready before the
// first one has been taken.
module round_robin_tick_scheduler_unit import rrts_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  rrts_cfg_if.sink   cfg_s,
  rrts_in_if.sink    in_s,
  rrts_out_if.source out_s
);

  cfg_t cfg_q;
  logic op_valid, op_pop;
  op_t  op;

  assign cfg_s.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.quantum <= 16'd1;
      cfg_q.count <= CntW'(1);
    end else if (cfg_s.valid) begin
      case (cfg_s.index)
        REG_QUANTUM: cfg_q.quantum <= cfg_s.wdata;
        REG_PCOUNT:  cfg_q.count <= cfg_s.wdata[CntW-1:0];
        default: ;
      endcase
    end
  end

  rrts_front u_front (
    .clk_i, .rst_ni, .in_s,
    .op_valid_o(op_valid), .op_o(op), .op_pop_i(op_pop)
  );

  rrts_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .op_valid_i(op_valid), .op_i(op), .op_pop_o(op_pop), .out_s
  );

endmodule

[design/rrts_front.sv]
// Front end: accepts input beats, classifies them and queues decoded operations.
`timescale 1ns / 1ps
module rrts_front import rrts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rrts_in_if.sink    in_s,
  output logic       op_valid_o,
  output op_t        op_o,
  input  logic       op_pop_i
);

  op_t         mem_q [QDepth];
  logic        wr_q, rd_q;
  logic [1:0]  cnt_q;
  logic        push;
  op_t         dec;

  assign in_s.ready = (cnt_q != 2'(QDepth));
  assign push = in_s.valid && in_s.ready;
  assign op_valid_o = (cnt_q != 2'd0);
  assign op_o = mem_q[rd_q];

  always_comb begin
    dec.is_tick = (in_s.data.command == CMD_TICK);
    dec.idx     = in_s.data.proc_index[IdxW-1:0];
    dec.idx_ok  = ({28'd0, in_s.data.proc_index} < 32'(MaxProcs));
    dec.arrival = in_s.data.arrival_tick;
    dec.burst   = in_s.data.burst_length;
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0;
      rd_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (op_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, op_pop_i};
    end
  end

endmodule

[design/rrts_back.sv]
// Back end: sequencer that walks the process table for each load and tick command.
`timescale 1ns / 1ps
module rrts_back import rrts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       op_valid_i,
  input  op_t        op_i,
  output logic       op_pop_o,
  rrts_out_if.source out_s
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_ARR  = 6'b000010,
    ST_PICK = 6'b000100,
    ST_RUN  = 6'b001000,
    ST_AGE  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [15:0] arr_q  [MaxProcs];
  logic [15:0] lrn_q  [MaxProcs];
  logic [15:0] rem_q  [MaxProcs];
  logic [15:0] age_q  [MaxProcs];
  logic [15:0] wait_q [MaxProcs];
  logic [MaxProcs-1:0] rdy_q, res_q;

  logic [15:0] tick_q, qleft_q;
  logic        busy_q;
  logic [IdxW-1:0] cur_q;

  logic [CntW-1:0] i_q;
  logic [IdxW-1:0] ix;
  op_t         op_q;
  logic        found_q, anyrdy_q, alldone_q, fin_q;
  logic [15:0] best_q;
  logic [IdxW-1:0] c_q;
  logic [15:0] fw_q, ft_q;
  logic [1:0]  pmode_q;
  logic        oval_q;
  out_item_t   odat_q;

  logic [15:0]   effq;
  logic [CntW-1:0] n;
  logic          last;
  logic          cur_rdy;
  logic          out_free;
  logic [15:0]   gap;
  logic [16:0]   wsum;
  logic [15:0]   new_wait;

  assign effq = (cfg_i.quantum == 16'd0) ? 16'd1 : cfg_i.quantum;
  assign n = (cfg_i.count > CntW'(MaxProcs)) ? CntW'(MaxProcs) : cfg_i.count;
  assign ix = i_q[IdxW-1:0];
  assign last = (i_q + CntW'(1) >= n);
  assign cur_rdy = ({1'b0, cur_q} < n) && rdy_q[cur_q];
  assign out_free = !oval_q || out_s.ready;

  // Waiting gap of the chosen entry, added on the first run of a quantum.
  assign gap = (tick_q >= lrn_q[c_q]) ? tick_q - lrn_q[c_q] : 16'd0;
  assign wsum = {1'b0, wait_q[c_q]} + {1'b0, gap};
  assign new_wait = wsum[16] ? 16'hFFFF : wsum[15:0];

  assign op_pop_o = (state_q == ST_IDLE) && op_valid_i;
  assign out_s.valid = oval_q;
  assign out_s.data = odat_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (op_pop_o) state_d = op_i.is_tick ? ST_ARR : ST_AGE;
      ST_ARR:  if (last || n == '0) state_d = ST_PICK;
      ST_PICK: begin
        if (pmode_q == 2'd0) begin
          if (cur_rdy) state_d = ST_RUN;
        end else if (last || n == '0) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN:  if (!(pmode_q == 2'd2 && !found_q && cur_rdy)) state_d = ST_AGE;
      ST_AGE:  if (last || n == '0) state_d = ST_OUT;
      ST_OUT:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Per-entry scans share one index counter; one entry per cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: if (op_pop_o && !op_i.is_tick && op_i.idx_ok) begin
        arr_q[op_i.idx] <= op_i.arrival;
        lrn_q[op_i.idx] <= op_i.arrival;
        wait_q[op_i.idx] <= 16'd0;
      end
      ST_RUN: if (found_q) begin
        if (!res_q[c_q]) wait_q[c_q] <= new_wait;
        lrn_q[c_q] <= (tick_q == 16'hFFFF) ? 16'hFFFF : tick_q + 16'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      for (int k = 0; k < MaxProcs; k++) begin
        rem_q[k] <= 16'd0;
        age_q[k] <= 16'd0;
      end
      rdy_q <= '0;
      res_q <= '0;
      tick_q <= 16'd0;
      qleft_q <= 16'd1;
      busy_q <= 1'b0;
      cur_q <= '0;
      i_q <= '0;
      op_q <= '0;
      found_q <= 1'b0;
      anyrdy_q <= 1'b0;
      alldone_q <= 1'b1;
      fin_q <= 1'b0;
      best_q <= 16'd0;
      c_q <= '0;
      fw_q <= 16'd0;
      ft_q <= 16'd0;
      pmode_q <= 2'd0;
      oval_q <= 1'b0;
      odat_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) oval_q <= 1'b1;
      else if (oval_q && out_s.ready) oval_q <= 1'b0;
      case (state_q)
        ST_IDLE: if (op_pop_o) begin
          op_q <= op_i;
          i_q <= '0;
          found_q <= 1'b0;
          fin_q <= 1'b0;
          best_q <= 16'd0;
          c_q <= '0;
          alldone_q <= 1'b1;
          anyrdy_q <= 1'b0;
          if (!op_i.is_tick && op_i.idx_ok) begin
            rem_q[op_i.idx] <= op_i.burst;
            rdy_q[op_i.idx] <= 1'b0;
            age_q[op_i.idx] <= 16'd0;
            res_q[op_i.idx] <= 1'b0;
          end
        end
        ST_ARR: begin
          if (n != '0 && rem_q[ix] != 16'd0 && !rdy_q[ix] && arr_q[ix] == tick_q) begin
            rdy_q[ix] <= 1'b1;
            age_q[ix] <= 16'd1;
          end
          i_q <= last ? '0 : i_q + CntW'(1);
          if (last || n == '0) begin
            if (!busy_q) pmode_q <= 2'd1;
            else if (qleft_q != effq) pmode_q <= 2'd0;
            else pmode_q <= 2'd2;
          end
        end
        ST_PICK: begin
          if (pmode_q == 2'd0) begin
            if (cur_rdy) begin
              found_q <= 1'b1;
              c_q <= cur_q;
            end else begin
              pmode_q <= 2'd2;
            end
          end else if (n != '0) begin
            if (pmode_q == 2'd1) begin
              if (!found_q && rdy_q[ix]) begin
                found_q <= 1'b1;
                c_q <= ix;
              end
            end else if (rdy_q[ix] && age_q[ix] > best_q) begin
              best_q <= age_q[ix];
              c_q <= ix;
              found_q <= 1'b1;
            end
            i_q <= last ? '0 : i_q + CntW'(1);
          end
        end
        ST_RUN: begin
          if (pmode_q == 2'd2 && !found_q && cur_rdy) begin
            // No aged candidate: the current process keeps the processor.
            found_q <= 1'b1;
            c_q <= cur_q;
          end else if (found_q) begin
            busy_q <= 1'b1;
            cur_q <= c_q;
            // The entry stays resumed unless its quantum runs out without finishing.
            res_q[c_q] <= !(rem_q[c_q] != 16'd1 && qleft_q == 16'd1);
            rem_q[c_q] <= rem_q[c_q] - 16'd1;
            if (rem_q[c_q] == 16'd1) begin
              fin_q <= 1'b1;
              qleft_q <= effq;
              rdy_q[c_q] <= 1'b0;
              fw_q <= res_q[c_q] ? wait_q[c_q] : new_wait;
              ft_q <= ({1'b0, tick_q} + 17'd1 >= {1'b0, arr_q[c_q]}) ?
                (({1'b0, tick_q} + 17'd1 - {1'b0, arr_q[c_q]} > 17'hFFFF) ? 16'hFFFF :
                 16'(tick_q + 16'd1 - arr_q[c_q])) : 16'd0;
            end else if (qleft_q == 16'd1) begin
              qleft_q <= effq;
            end else begin
              qleft_q <= qleft_q - 16'd1;
            end
          end
          i_q <= '0;
        end
        ST_AGE: begin
          if (op_q.is_tick && n != '0) begin
            if (found_q) begin
              if (rdy_q[ix] && ix != c_q)
                age_q[ix] <= (age_q[ix] == 16'hFFFF) ? 16'hFFFF : age_q[ix] + 16'd1;
              else
                age_q[ix] <= 16'd0;
              if (rdy_q[ix]) anyrdy_q <= 1'b1;
            end
            if (rem_q[ix] != 16'd0) alldone_q <= 1'b0;
            i_q <= last ? '0 : i_q + CntW'(1);
          end else if (!op_q.is_tick && n != '0) begin
            if (rem_q[ix] != 16'd0) alldone_q <= 1'b0;
            i_q <= last ? '0 : i_q + CntW'(1);
          end
        end
        ST_OUT: if (out_free) begin
          if (found_q && fin_q) busy_q <= anyrdy_q;
          if (op_q.is_tick) tick_q <= (tick_q == 16'hFFFF) ? 16'hFFFF : tick_q + 16'd1;
          odat_q.running_valid <= found_q;
          odat_q.running_index <= found_q ? 4'(c_q) : 4'd0;
          odat_q.finished <= fin_q;
          odat_q.finished_wait <= fin_q ? fw_q : 16'd0;
          odat_q.finished_turnaround <= fin_q ? ft_q : 16'd0;
          odat_q.all_done <= alldone_q;
          odat_q.tick_now <= op_q.is_tick ?
            ((tick_q == 16'hFFFF) ? 16'hFFFF : tick_q + 16'd1) : tick_q;
        end
        default: ;
      endcase
    end
  end

endmodule

[design/rrts_checker.sv]
// Port-level assertions for the scheduler, bound to the top level.
`timescale 1ns / 1ps
module rrts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic        running_valid,
  input logic [3:0]  running_index,
  input logic        finished,
  input logic [15:0] finished_wait
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");

  a_fin_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && finished |-> running_valid) else $error("finish without run");

  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !running_valid |-> running_index == 4'd0) else $error("stray index");

  a_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !finished |-> finished_wait == 16'd0) else $error("stray wait");

endmodule

bind round_robin_tick_scheduler_unit rrts_checker u_rrts_checker (
  .clk_i(clk_i), .rst_ni(rst_ni),
  .out_valid(out_s.valid), .out_ready(out_s.ready),
  .running_valid(out_s.data.running_valid),
  .running_index(out_s.data.running_index),
  .finished(out_s.data.finished),
  .finished_wait(out_s.data.finished_wait)
);
